// ----- hw/rtl/faot_pkg.sv -----
// faot_pkg: shared types and constants for the frame-aged object tracker.
// Used by faot_ctrl, faot_dp and frame_aged_object_tracker. No dependencies.
package faot_pkg;

    localparam int DEF_TABLE_ENTRIES = 32;
    localparam int DEF_TAG_BITS      = 16;

    localparam int TAG_IN_W = 16;
    localparam int FRAME_W  = 32;
    localparam int WORK_W   = 16;
    localparam int SLOT_W   = 5;
    localparam int TOTAL_W  = 24;
    localparam int OUT_W    = 2;

    typedef enum logic [OUT_W-1:0] {
        OUT_CONT = 2'd0,
        OUT_NEW  = 2'd1,
        OUT_DROP = 2'd2
    } t_outcome;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic evict;
        logic place;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

// ----- hw/rtl/frame_aged_object_tracker.sv -----
// Frame-aged object tracker, top level. Each accepted item runs an evict phase and then
// a match/allocate phase over the shared flop table; the place phase loads the result
// register and can accept the next item, but waits while an unread result is held.
// A new item is taken while the previous result still waits in the output register.
// Reset (synchronous, active low) frees all entries, zeroes stamps and the total;
// tags are not reset. Depends on faot_pkg, faot_ctrl, faot_dp.
module frame_aged_object_tracker #(
    parameter int TABLE_ENTRIES = faot_pkg::DEF_TABLE_ENTRIES,
    parameter int TAG_BITS      = faot_pkg::DEF_TAG_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [faot_pkg::TAG_IN_W-1:0]  i_object_tag,
    input  logic [faot_pkg::FRAME_W-1:0]   i_frame_number,
    input  logic [faot_pkg::WORK_W-1:0]    i_work_count,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [faot_pkg::OUT_W-1:0]     o_outcome,
    output logic [faot_pkg::SLOT_W-1:0]    o_slot_index,
    output logic [faot_pkg::TOTAL_W-1:0]   o_frame_total
);
    import faot_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Controller: idle -> evict -> place; place hands off straight into the next
    // item's evict when a new item arrives as the result is written.
    faot_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath: evict phase checks for a new frame and frees stale entries;
    // place phase restamps a continuing entry or fills the lowest free one,
    // adds work with saturation and loads the result register.
    faot_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .TAG_BITS      (TAG_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_object_tag   (i_object_tag),
        .i_frame_number (i_frame_number),
        .i_work_count   (i_work_count),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_outcome      (o_outcome),
        .o_slot_index   (o_slot_index),
        .o_frame_total  (o_frame_total)
    );

endmodule

// ----- hw/rtl/faot_ctrl.sv -----
// faot_ctrl: sequencer for the tracker, one evict phase and one place phase per item.
// Depends on faot_pkg.
module faot_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  faot_pkg::t_status i_status,
    output faot_pkg::t_cmd    o_cmd
);
    import faot_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVICT,
        S_PLACE
    } t_state;

    t_state r_state;
    logic   accept;
    logic   place_go;

    assign place_go   = (r_state == S_PLACE) && i_status.out_free;
    assign o_in_ready = (r_state == S_IDLE) || place_go;
    assign accept     = i_in_valid && o_in_ready;

    assign o_cmd.load  = accept;
    assign o_cmd.evict = (r_state == S_EVICT);
    assign o_cmd.place = place_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EVICT;
                    end
                end
                S_EVICT: begin
                    r_state <= S_PLACE;
                end
                S_PLACE: begin
                    if (place_go) begin
                        r_state <= accept ? S_EVICT : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/faot_dp.sv -----
// faot_dp: entry table, parallel stamp/tag compare, running total and result register.
// Depends on faot_pkg.
module faot_dp #(
    parameter int TABLE_ENTRIES = faot_pkg::DEF_TABLE_ENTRIES,
    parameter int TAG_BITS      = faot_pkg::DEF_TAG_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  faot_pkg::t_cmd                 i_cmd,
    output faot_pkg::t_status              o_status,
    input  logic [faot_pkg::TAG_IN_W-1:0]  i_object_tag,
    input  logic [faot_pkg::FRAME_W-1:0]   i_frame_number,
    input  logic [faot_pkg::WORK_W-1:0]    i_work_count,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [faot_pkg::OUT_W-1:0]     o_outcome,
    output logic [faot_pkg::SLOT_W-1:0]    o_slot_index,
    output logic [faot_pkg::TOTAL_W-1:0]   o_frame_total
);
    import faot_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // entry table
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [TAG_BITS-1:0]      r_tag   [TABLE_ENTRIES];
    logic [FRAME_W-1:0]       r_stamp [TABLE_ENTRIES];
    logic [TOTAL_W-1:0]       r_total;

    // latched item
    logic [TAG_BITS-1:0] r_tag_in;
    logic [FRAME_W-1:0]  r_now;
    logic [WORK_W-1:0]   r_work;

    // result register
    logic                r_out_valid;
    t_outcome            r_outcome;
    logic [SLOT_W-1:0]   r_slot;
    logic [TOTAL_W-1:0]  r_out_total;

    logic [FRAME_W-1:0]       prev;
    logic [TABLE_ENTRIES-1:0] is_now;
    logic [TABLE_ENTRIES-1:0] is_prev;
    logic [TABLE_ENTRIES-1:0] hit;
    logic                     seen;
    logic                     hit_any;
    logic                     free_any;
    logic [IDX_W-1:0]         hit_idx;
    logic [IDX_W-1:0]         free_idx;
    logic [TOTAL_W:0]         sum;
    logic [TOTAL_W-1:0]       n_total;

    assign prev = r_now - FRAME_W'(1);

    always_comb begin
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            is_now[k]  = (r_stamp[k] == r_now);
            is_prev[k] = (r_stamp[k] == prev);
            hit[k]     = r_valid[k] && is_prev[k] && (r_tag[k] == r_tag_in);
        end
    end

    assign seen     = |is_now;
    assign hit_any  = |hit;
    assign free_any = ~&r_valid;

    // lowest index wins
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
            if (hit[k]) begin
                hit_idx = IDX_W'(k);
            end
            if (!r_valid[k]) begin
                free_idx = IDX_W'(k);
            end
        end
    end

    assign sum     = {1'b0, r_total} + (TOTAL_W + 1)'(r_work);
    assign n_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tag_in <= TAG_BITS'(i_object_tag);
            r_now    <= i_frame_number;
            r_work   <= i_work_count;
        end
    end

    // tags are only read under a valid bit, so no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.place && !hit_any && free_any) begin
            r_tag[free_idx] <= r_tag_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.place) begin
            if (hit_any) begin
                r_outcome   <= OUT_CONT;
                r_slot      <= SLOT_W'(hit_idx);
                r_out_total <= n_total;
            end else if (free_any) begin
                r_outcome   <= OUT_NEW;
                r_slot      <= SLOT_W'(free_idx);
                r_out_total <= n_total;
            end else begin
                r_outcome   <= OUT_DROP;
                r_slot      <= '0;
                r_out_total <= r_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                r_stamp[k] <= '0;
            end
        end else begin
            if (i_cmd.evict && !seen) begin
                // new frame: clear total, free entries not seen last frame
                r_total <= '0;
                r_valid <= r_valid & is_prev;
            end
            if (i_cmd.place) begin
                if (hit_any) begin
                    r_stamp[hit_idx] <= r_now;
                    r_total          <= n_total;
                end else if (free_any) begin
                    r_valid[free_idx] <= 1'b1;
                    r_stamp[free_idx] <= r_now;
                    r_total           <= n_total;
                end
            end
            if (i_cmd.place) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_outcome     = r_outcome;
    assign o_slot_index  = r_slot;
    assign o_frame_total = r_out_total;

endmodule

// ----- dv/frame_aged_object_tracker_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for frame_aged_object_tracker: directed items, a saturation
// ladder and random frame traffic, all checked against a tracking scoreboard.
// Depends on faot_pkg and the frame_aged_object_tracker RTL.

typedef struct {
    faot_pkg::t_outcome              outcome;
    logic [faot_pkg::SLOT_W-1:0]     slot;
    logic [faot_pkg::TOTAL_W-1:0]    total;
} t_tracker_status;

class tracker_scoreboard;
    localparam int N = faot_pkg::DEF_TABLE_ENTRIES;
    localparam logic [faot_pkg::TAG_IN_W-1:0] TAG_MASK =
        faot_pkg::TAG_IN_W'((64'd1 << faot_pkg::DEF_TAG_BITS) - 1);

    bit                               ent_valid [N];
    logic [faot_pkg::TAG_IN_W-1:0]    ent_tag   [N];
    logic [faot_pkg::FRAME_W-1:0]     ent_stamp [N];
    logic [faot_pkg::TOTAL_W-1:0]     frame_sum;
    t_tracker_status                  status_due [$];

    int errors;
    int n_checked;
    int n_cont;
    int n_new;
    int n_drop;
    int n_sat;

    function new();
        for (int k = 0; k < N; k++) begin
            ent_valid[k] = 1'b0;
            ent_tag[k]   = '0;
            ent_stamp[k] = '0;
        end
        frame_sum = '0;
        errors    = 0;
        n_checked = 0;
        n_cont    = 0;
        n_new     = 0;
        n_drop    = 0;
        n_sat     = 0;
    endfunction

    // Accepted input item: update the table copy and queue the status it must produce.
    function void register_object(logic [faot_pkg::TAG_IN_W-1:0] tag_in,
                                  logic [faot_pkg::FRAME_W-1:0] frame,
                                  logic [faot_pkg::WORK_W-1:0] work);
        logic [faot_pkg::TAG_IN_W-1:0] tag;
        logic [faot_pkg::FRAME_W-1:0]  prev;
        logic [faot_pkg::TOTAL_W:0]    sum;
        bit                            seen;
        int                            slot;
        faot_pkg::t_outcome            oc;
        t_tracker_status               st;

        tag  = tag_in & TAG_MASK;
        prev = frame - 1'b1;
        seen = 1'b0;
        slot = -1;
        oc   = faot_pkg::OUT_DROP;

        // freed entries keep their stamp, so they count for the frame test too
        for (int k = 0; k < N; k++)
            if (ent_stamp[k] == frame) seen = 1'b1;

        if (!seen) begin
            frame_sum = '0;
            for (int k = 0; k < N; k++)
                if (ent_valid[k] && ent_stamp[k] != prev) ent_valid[k] = 1'b0;
        end

        for (int k = 0; k < N; k++) begin
            if (slot < 0 && ent_valid[k] && ent_tag[k] == tag && ent_stamp[k] == prev) begin
                slot = k;
                oc   = faot_pkg::OUT_CONT;
            end
        end

        if (slot < 0) begin
            for (int k = 0; k < N; k++) begin
                if (slot < 0 && !ent_valid[k]) begin
                    slot         = k;
                    oc           = faot_pkg::OUT_NEW;
                    ent_valid[k] = 1'b1;
                    ent_tag[k]   = tag;
                end
            end
        end

        if (slot >= 0) begin
            ent_stamp[slot] = frame;
            sum       = {1'b0, frame_sum} + work;
            frame_sum = sum[faot_pkg::TOTAL_W] ? '1 : sum[faot_pkg::TOTAL_W-1:0];
        end

        st.outcome = oc;
        st.slot    = (slot >= 0) ? faot_pkg::SLOT_W'(slot) : '0;
        st.total   = frame_sum;
        status_due.push_back(st);

        case (oc)
            faot_pkg::OUT_CONT: n_cont++;
            faot_pkg::OUT_NEW:  n_new++;
            default:            n_drop++;
        endcase
        if (&frame_sum) n_sat++;
    endfunction

    function void check_status(logic [faot_pkg::OUT_W-1:0] oc,
                               logic [faot_pkg::SLOT_W-1:0] slot,
                               logic [faot_pkg::TOTAL_W-1:0] tot);
        t_tracker_status st;
        if (status_due.size() == 0) begin
            $display("%0t: unexpected result outcome=%0d slot=%0d total=%0d",
                     $time, oc, slot, tot);
            errors++;
            return;
        end
        st = status_due.pop_front();
        n_checked++;
        if (oc !== st.outcome) begin
            $display("%0t: outcome mismatch, expected %0d actual %0d", $time, st.outcome, oc);
            errors++;
        end
        if (slot !== st.slot) begin
            $display("%0t: slot_index mismatch, expected %0d actual %0d", $time, st.slot, slot);
            errors++;
        end
        if (tot !== st.total) begin
            $display("%0t: frame_total mismatch, expected %0d actual %0d",
                     $time, st.total, tot);
            errors++;
        end
    endfunction

    function int pending();
        return status_due.size();
    endfunction
endclass

module frame_aged_object_tracker_tb;
    import faot_pkg::*;

    localparam int N          = DEF_TABLE_ENTRIES;
    // directed and ladder items come to about 880, random traffic tops it up to ~1000
    localparam int RAND_ITEMS = 130;
    // slowest legal run (long gaps, long stalls, one hold-off) stays well under this limit
    localparam int CYCLE_LIMIT = 1000000;
    // receiver hold-off: starts once this many results have been checked
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [TAG_IN_W-1:0]  i_object_tag;
    logic [FRAME_W-1:0]   i_frame_number;
    logic [WORK_W-1:0]    i_work_count;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [OUT_W-1:0]     o_outcome;
    logic [SLOT_W-1:0]    o_slot_index;
    logic [TOTAL_W-1:0]   o_frame_total;

    tracker_scoreboard book;
    int  cycles;
    int  n_sent;
    bit  calm;      // when set, neither side idles

    frame_aged_object_tracker dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_object_tag   (i_object_tag),
        .i_frame_number (i_frame_number),
        .i_work_count   (i_work_count),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_outcome      (o_outcome),
        .o_slot_index   (o_slot_index),
        .o_frame_total  (o_frame_total)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycles, book.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Idle length: mostly zero or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)   return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    // Offer one item; payload changes only at the falling edge, acceptance is seen at
    // the rising edge. Valid stays high across back-to-back items.
    task automatic send_item(logic [TAG_IN_W-1:0] tag, logic [FRAME_W-1:0] frame,
                             logic [WORK_W-1:0] work);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_object_tag   = tag;
        i_frame_number = frame;
        i_work_count   = work;
        do @(posedge i_clk); while (!o_in_ready);
        book.register_object(tag, frame, work);
        n_sent++;
    endtask

    // Short directed set: empty table at frame 0, field extremes, continuation,
    // repeat of a tag inside one frame, and the wrap from frame 2^32-1 to frame 0.
    task automatic directed_items();
        send_item(16'h0000, 32'h0000_0000, 16'h0000);   // frame 0 is not new after reset
        send_item(16'hFFFF, 32'h0000_0000, 16'hFFFF);
        send_item(16'h0000, 32'h0000_0001, 16'h0001);   // new frame, continues entry 0
        send_item(16'hFFFF, 32'h0000_0001, 16'h1234);
        send_item(16'h0000, 32'h0000_0001, 16'h0005);   // same tag twice in a frame
        send_item(16'h8000, 32'hFFFF_FFFF, 16'h7FFF);   // frees everything
        send_item(16'h8000, 32'h0000_0000, 16'h8000);   // wrap: stale stamp 0 keeps frame
        send_item(16'h8000, 32'h0000_0001, 16'hFFFF);
        send_item(16'h5555, 32'hAAAA_AAAA, 16'hAAAA);
        send_item(16'hAAAA, 32'h5555_5555, 16'h5555);
        send_item(16'hAAAA, 32'h5555_5556, 16'h0000);
    endtask

    // Saturation needs many adds without a frame clear. Build a ladder of stale
    // stamps, refill the freed entries at those stale frames, then walk entries up
    // the ladder so every item continues. Also hits table-full drops twice.
    task automatic saturation_ladder();
        logic [FRAME_W-1:0]  base_frame;
        logic [TAG_IN_W-1:0] tag_base;
        logic [TAG_IN_W-1:0] ladder_tag [N];

        base_frame = 32'h1000_0000;
        tag_base   = TAG_IN_W'($urandom());
        for (int i = 0; i < N; i++) ladder_tag[i] = tag_base + TAG_IN_W'(i);

        // new frame clears the table, then fill it and overflow by one
        for (int i = 0; i < N; i++)
            send_item(ladder_tag[i], base_frame + 1, WORK_W'($urandom()));
        send_item(tag_base + TAG_IN_W'(N), base_frame + 1, WORK_W'($urandom()));

        // staircase: entry i stops at frame base+i+1 and is freed with that stamp
        for (int j = 2; j <= N; j++)
            for (int i = j - 1; i < N; i++)
                send_item(ladder_tag[i], base_frame + FRAME_W'(j), WORK_W'($urandom()));

        // stale frames are seen again: refill entry i without clearing the total
        for (int i = 0; i <= N - 3; i++)
            send_item(ladder_tag[i], base_frame + FRAME_W'(i + 1), 16'hFFFF);

        // walk low entries to the top, one continuation per frame
        for (int p = 0; p < 12; p++)
            for (int v = p + 2; v <= N; v++)
                send_item(ladder_tag[p], base_frame + FRAME_W'(v), 16'hFFFF);

        // table full again, total saturated
        send_item(tag_base + TAG_IN_W'(N), base_frame + FRAME_W'(N), WORK_W'($urandom()));
    endtask

    // Random frames: mostly step by one with tags reused from a pool, so entries
    // carry over; also repeats, backward steps, jumps and bursts big enough to fill.
    task automatic random_frames(int count);
        logic [FRAME_W-1:0]  cur;
        logic [TAG_IN_W-1:0] pool [48];
        logic [TAG_IN_W-1:0] tag;
        logic [WORK_W-1:0]   work;
        int sent_here;
        int burst;
        int pool_hi;
        int r;

        sent_here = 0;
        cur = $urandom();
        for (int k = 0; k < 48; k++) pool[k] = TAG_IN_W'($urandom());

        while (sent_here < count) begin
            r = $urandom_range(0, 99);
            if (r < 65)      cur = cur + 1;
            else if (r < 75) cur = cur;
            else if (r < 85) cur = $urandom();
            else if (r < 92) cur = cur - FRAME_W'($urandom_range(1, 3));
            else             cur = cur + FRAME_W'($urandom_range(2, 5));

            burst   = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 10)
                                                 : $urandom_range(20, 40);
            pool_hi = $urandom_range(3, 47);
            calm    = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 15) == 0)
                for (int k = 0; k < 8; k++) pool[$urandom_range(0, 47)] = TAG_IN_W'($urandom());

            for (int k = 0; k < burst; k++) begin
                if ($urandom_range(0, 4) == 0) tag = TAG_IN_W'($urandom());
                else                           tag = pool[$urandom_range(0, pool_hi)];
                r = $urandom_range(0, 9);
                if (r == 0)      work = '0;
                else if (r == 1) work = '1;
                else             work = WORK_W'($urandom());
                send_item(tag, cur, work);
                sent_here++;
            end
        end
        calm = 1'b0;
    endtask

    // Receiver: random ready pattern, plus one long hold-off so the block backs up
    // and stalls its input while the sender keeps offering.
    initial begin
        int  rdy_left;
        int  hold_left;
        int  g;
        bit  held;
        rdy_left  = 0;
        hold_left = 0;
        held      = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else if (!held && book.n_checked >= HOLD_AT) begin
                held        = 1'b1;
                hold_left   = HOLD_CYCLES - 1;
                i_out_ready = 1'b0;
            end else if (calm) begin
                i_out_ready = 1'b1;
            end else if (rdy_left > 0) begin
                rdy_left--;
            end else if (i_out_ready) begin
                g = pick_gap();
                if (g > 0) begin
                    i_out_ready = 1'b0;
                    rdy_left    = g - 1;
                end else begin
                    rdy_left = $urandom_range(0, 10);
                end
            end else begin
                i_out_ready = 1'b1;
                rdy_left    = $urandom_range(0, 15);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            book.check_status(o_outcome, o_slot_index, o_frame_total);
    end

    initial begin
        book           = new();
        cycles         = 0;
        n_sent         = 0;
        calm           = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_object_tag   = '0;
        i_frame_number = '0;
        i_work_count   = '0;
        i_out_ready    = 1'b0;

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_items();
        saturation_ladder();
        random_frames(RAND_ITEMS);

        @(negedge i_clk);
        i_in_valid = 1'b0;

        while (book.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d items over %0d cycles; %0d results checked.",
                 n_sent, cycles, book.n_checked);
        $display("Outcomes: %0d continued, %0d placed, %0d dropped; %0d at saturated total.",
                 book.n_cont, book.n_new, book.n_drop, book.n_sat);
        if (book.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", book.errors);
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/faot_pkg.sv
hw/rtl/faot_ctrl.sv
hw/rtl/faot_dp.sv
hw/rtl/frame_aged_object_tracker.sv
dv/frame_aged_object_tracker_tb.sv
